// ----- sv/ptts_pkg.sv -----
// ============================================================================
// Periodic task table scheduler - shared definitions
// Word formats, request and result codes, table entry layout, controller
// states and the command/status bundles between controller and datapath.
// ============================================================================
`default_nettype none

package ptts_pkg;

    localparam int TABLE_SLOTS_DEF = 8;
    localparam int MAX_RESULTS     = 8;
    localparam int EMIT_CNT_W      = $clog2(MAX_RESULTS + 1);

    // Request codes
    localparam logic [1:0] REQ_SET      = 2'd0;
    localparam logic [1:0] REQ_DELETE   = 2'd1;
    localparam logic [1:0] REQ_TICK     = 2'd2;
    localparam logic [1:0] REQ_DISPATCH = 2'd3;

    // Result codes
    localparam logic [2:0] KIND_UPDATED   = 3'd0;
    localparam logic [2:0] KIND_ADDED     = 3'd1;
    localparam logic [2:0] KIND_FULL      = 3'd2;
    localparam logic [2:0] KIND_REMOVED   = 3'd3;
    localparam logic [2:0] KIND_NOT_FOUND = 3'd4;
    localparam logic [2:0] KIND_INVALID   = 3'd5;
    localparam logic [2:0] KIND_DUE       = 3'd6;

    typedef struct packed {
        logic [1:0]  req_type;
        logic [7:0]  task_id;
        logic [15:0] start_delay;
        logic [15:0] run_period;
    } req_word_t;

    typedef struct packed {
        logic [2:0] result_kind;
        logic [7:0] result_id;
        logic       last_of_run;
    } res_word_t;

    typedef struct packed {
        logic [7:0]  id;
        logic [15:0] delay;
        logic [15:0] period;
        logic        runnable;
    } entry_t;

    // Source of the data written into the table
    typedef enum logic [1:0] {
        WR_NEW,
        WR_TICK,
        WR_DISP,
        WR_MOVE
    } wr_sel_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DECODE,
        ST_SRCH_RD,
        ST_SRCH_CHK,
        ST_DEL_MOVE,
        ST_TICK_RD,
        ST_TICK_WR,
        ST_DISP_RD,
        ST_DISP_CHK,
        ST_DISP_MOVE,
        ST_FINISH
    } state_t;

    typedef struct packed {
        logic       load_req;
        logic       idx_clear;
        logic       idx_inc;
        logic       rd_en;
        logic       rd_last;
        logic       wr_en;
        wr_sel_t    wr_sel;
        logic       count_inc;
        logic       count_dec;
        logic       pend_set;
        logic       pend_clr;
        logic       emit;
        logic [2:0] emit_kind;
        logic       flush;
    } cmd_t;

    typedef struct packed {
        logic [1:0] req_type;
        logic       id_zero;
        logic       pending;
        logic       at_end;
        logic       is_last;
        logic       full;
        logic       match;
        logic       runnable;
        logic       period_zero;
        logic       emit_ready;
        logic       flush_ready;
    } status_t;

endpackage

`default_nettype wire

// ----- sv/ptts_dpath.sv -----
// ============================================================================
// Periodic task table scheduler - datapath
// Task table memory, walk index, entry count, tick flag, result hold stage
// and output register.
// ============================================================================
`default_nettype none

module ptts_dpath #(
    parameter int TABLE_SLOTS = ptts_pkg::TABLE_SLOTS_DEF
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire ptts_pkg::req_word_t req,
    input  wire ptts_pkg::cmd_t     cmd,
    output ptts_pkg::status_t       status,
    output logic                    res_valid,
    input  wire logic               res_stall,
    output ptts_pkg::res_word_t     res
);

    import ptts_pkg::*;

    localparam int AW = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;
    localparam int CW = $clog2(TABLE_SLOTS + 1);
    localparam logic [CW-1:0]         SLOTS_C = CW'(TABLE_SLOTS);
    localparam logic [EMIT_CNT_W-1:0] MAX_C   = EMIT_CNT_W'(MAX_RESULTS);

    entry_t mem [TABLE_SLOTS];

    req_word_t              req_reg;
    entry_t                 rd_data_reg;
    entry_t                 wr_data;
    logic [CW-1:0]          idx_reg, idx_next;
    logic [CW-1:0]          count_reg, count_next;
    logic [CW-1:0]          last_idx;
    logic [AW-1:0]          rd_addr;
    logic                   pend_reg, pend_next;
    logic                   hold_valid_reg, hold_valid_next;
    logic [2:0]             hold_kind_reg, hold_kind_next;
    logic [7:0]             hold_id_reg, hold_id_next;
    logic [EMIT_CNT_W-1:0]  emit_cnt_reg, emit_cnt_next;
    logic                   out_valid_reg, out_valid_next;
    res_word_t              out_reg, out_next;
    logic                   out_free;
    logic                   cap;
    logic                   emit_go;
    logic [7:0]             emit_id;

    assign last_idx = count_reg - CW'(1);
    assign rd_addr  = cmd.rd_last ? last_idx[AW-1:0] : idx_reg[AW-1:0];

    // Table write data
    always_comb
    begin
        wr_data = rd_data_reg;
        case (cmd.wr_sel)
            WR_NEW:
            begin
                wr_data.id       = req_reg.task_id;
                wr_data.delay    = req_reg.start_delay;
                wr_data.period   = req_reg.run_period;
                wr_data.runnable = 1'b0;
            end
            WR_TICK:
            begin
                if (rd_data_reg.delay == 16'd0)
                    wr_data.runnable = 1'b1;
                else
                    wr_data.delay = rd_data_reg.delay - 16'd1;
            end
            WR_DISP:
            begin
                wr_data.runnable = 1'b0;
                if (rd_data_reg.delay == 16'd0)
                    wr_data.delay = rd_data_reg.period - 16'd1;
            end
            default:
            begin
                wr_data = rd_data_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (cmd.rd_en)
            rd_data_reg <= mem[rd_addr];
        if (cmd.wr_en)
            mem[idx_reg[AW-1:0]] <= wr_data;
        if (cmd.load_req)
            req_reg <= req;
    end

    assign out_free = !out_valid_reg || !res_stall;
    assign cap      = (emit_cnt_reg == MAX_C);
    assign emit_go  = cmd.emit && !cap;
    assign emit_id  = (cmd.emit_kind == KIND_DUE) ? rd_data_reg.id : req_reg.task_id;

    always_comb
    begin
        idx_next = idx_reg;
        if (cmd.idx_clear)
            idx_next = '0;
        else if (cmd.idx_inc)
            idx_next = idx_reg + CW'(1);

        count_next = count_reg;
        if (cmd.count_inc)
            count_next = count_reg + CW'(1);
        else if (cmd.count_dec)
            count_next = count_reg - CW'(1);

        pend_next = pend_reg;
        if (cmd.pend_set)
            pend_next = 1'b1;
        else if (cmd.pend_clr)
            pend_next = 1'b0;

        out_valid_next  = out_valid_reg && res_stall;
        out_next        = out_reg;
        hold_valid_next = hold_valid_reg;
        hold_kind_next  = hold_kind_reg;
        hold_id_next    = hold_id_reg;
        emit_cnt_next   = emit_cnt_reg;

        // A new result pushes the held one out, not marked as last
        if (emit_go)
        begin
            hold_valid_next = 1'b1;
            hold_kind_next  = cmd.emit_kind;
            hold_id_next    = emit_id;
            emit_cnt_next   = emit_cnt_reg + EMIT_CNT_W'(1);
            if (hold_valid_reg)
            begin
                out_valid_next       = 1'b1;
                out_next.result_kind = hold_kind_reg;
                out_next.result_id   = hold_id_reg;
                out_next.last_of_run = 1'b0;
            end
        end
        else if (cmd.flush && hold_valid_reg)
        begin
            out_valid_next       = 1'b1;
            out_next.result_kind = hold_kind_reg;
            out_next.result_id   = hold_id_reg;
            out_next.last_of_run = 1'b1;
            hold_valid_next      = 1'b0;
        end

        if (cmd.load_req)
            emit_cnt_next = '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg        <= '0;
            count_reg      <= '0;
            pend_reg       <= 1'b0;
            hold_valid_reg <= 1'b0;
            emit_cnt_reg   <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            idx_reg        <= idx_next;
            count_reg      <= count_next;
            pend_reg       <= pend_next;
            hold_valid_reg <= hold_valid_next;
            emit_cnt_reg   <= emit_cnt_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        hold_kind_reg <= hold_kind_next;
        hold_id_reg   <= hold_id_next;
        out_reg       <= out_next;
    end

    always_comb
    begin
        status.req_type    = req_reg.req_type;
        status.id_zero     = (req_reg.task_id == 8'd0);
        status.pending     = pend_reg;
        status.at_end      = (idx_reg >= count_reg);
        status.is_last     = (idx_reg == last_idx);
        status.full        = (count_reg == SLOTS_C);
        status.match       = (rd_data_reg.id == req_reg.task_id);
        status.runnable    = rd_data_reg.runnable;
        status.period_zero = (rd_data_reg.period == 16'd0);
        status.emit_ready  = !hold_valid_reg || out_free || cap;
        status.flush_ready = !hold_valid_reg || out_free;
    end

    assign res_valid = out_valid_reg;
    assign res       = out_reg;

endmodule

`default_nettype wire

// ----- sv/ptts_ctrl.sv -----
// ============================================================================
// Periodic task table scheduler - controller
// Sequences search, append, delete, tick and dispatch walks over the table.
// ============================================================================
`default_nettype none

module ptts_ctrl (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              req_valid,
    output logic                   req_stall,
    input  wire ptts_pkg::status_t status,
    output ptts_pkg::cmd_t         cmd
);

    import ptts_pkg::*;

    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        req_stall  = 1'b1;
        case (state_reg)
            ST_IDLE:
            begin
                req_stall = 1'b0;
                if (req_valid)
                begin
                    cmd.load_req = 1'b1;
                    state_next   = ST_DECODE;
                end
            end
            ST_DECODE:
            begin
                case (status.req_type)
                    REQ_TICK:
                    begin
                        cmd.pend_set = 1'b1;
                        state_next   = ST_FINISH;
                    end
                    REQ_DISPATCH:
                    begin
                        cmd.idx_clear = 1'b1;
                        if (status.pending)
                        begin
                            cmd.pend_clr = 1'b1;
                            state_next   = ST_TICK_RD;
                        end
                        else
                            state_next = ST_DISP_RD;
                    end
                    default:
                    begin
                        if (status.id_zero)
                        begin
                            cmd.emit      = 1'b1;
                            cmd.emit_kind = KIND_INVALID;
                            state_next    = ST_FINISH;
                        end
                        else
                        begin
                            cmd.idx_clear = 1'b1;
                            state_next    = ST_SRCH_RD;
                        end
                    end
                endcase
            end
            ST_SRCH_RD:
            begin
                if (status.at_end)
                begin
                    cmd.emit   = 1'b1;
                    state_next = ST_FINISH;
                    if (status.req_type == REQ_SET)
                    begin
                        if (status.full)
                            cmd.emit_kind = KIND_FULL;
                        else
                        begin
                            cmd.wr_en     = 1'b1;
                            cmd.wr_sel    = WR_NEW;
                            cmd.count_inc = 1'b1;
                            cmd.emit_kind = KIND_ADDED;
                        end
                    end
                    else
                        cmd.emit_kind = KIND_NOT_FOUND;
                end
                else
                begin
                    cmd.rd_en  = 1'b1;
                    state_next = ST_SRCH_CHK;
                end
            end
            ST_SRCH_CHK:
            begin
                if (status.match)
                begin
                    cmd.emit = 1'b1;
                    if (status.req_type == REQ_SET)
                    begin
                        cmd.wr_en     = 1'b1;
                        cmd.wr_sel    = WR_NEW;
                        cmd.emit_kind = KIND_UPDATED;
                        state_next    = ST_FINISH;
                    end
                    else
                    begin
                        cmd.emit_kind = KIND_REMOVED;
                        if (status.is_last)
                        begin
                            cmd.count_dec = 1'b1;
                            state_next    = ST_FINISH;
                        end
                        else
                        begin
                            cmd.rd_en   = 1'b1;
                            cmd.rd_last = 1'b1;
                            state_next  = ST_DEL_MOVE;
                        end
                    end
                end
                else
                begin
                    cmd.idx_inc = 1'b1;
                    state_next  = ST_SRCH_RD;
                end
            end
            ST_DEL_MOVE:
            begin
                cmd.wr_en     = 1'b1;
                cmd.wr_sel    = WR_MOVE;
                cmd.count_dec = 1'b1;
                state_next    = ST_FINISH;
            end
            ST_TICK_RD:
            begin
                if (status.at_end)
                begin
                    cmd.idx_clear = 1'b1;
                    state_next    = ST_DISP_RD;
                end
                else
                begin
                    cmd.rd_en  = 1'b1;
                    state_next = ST_TICK_WR;
                end
            end
            ST_TICK_WR:
            begin
                cmd.wr_en   = 1'b1;
                cmd.wr_sel  = WR_TICK;
                cmd.idx_inc = 1'b1;
                state_next  = ST_TICK_RD;
            end
            ST_DISP_RD:
            begin
                if (status.at_end)
                    state_next = ST_FINISH;
                else
                begin
                    cmd.rd_en  = 1'b1;
                    state_next = ST_DISP_CHK;
                end
            end
            ST_DISP_CHK:
            begin
                if (!status.runnable)
                begin
                    cmd.idx_inc = 1'b1;
                    state_next  = ST_DISP_RD;
                end
                else if (status.emit_ready)
                begin
                    cmd.emit      = 1'b1;
                    cmd.emit_kind = KIND_DUE;
                    if (status.period_zero)
                    begin
                        if (status.is_last)
                        begin
                            cmd.count_dec = 1'b1;
                            cmd.idx_inc   = 1'b1;
                            state_next    = ST_DISP_RD;
                        end
                        else
                        begin
                            cmd.rd_en   = 1'b1;
                            cmd.rd_last = 1'b1;
                            state_next  = ST_DISP_MOVE;
                        end
                    end
                    else
                    begin
                        cmd.wr_en   = 1'b1;
                        cmd.wr_sel  = WR_DISP;
                        cmd.idx_inc = 1'b1;
                        state_next  = ST_DISP_RD;
                    end
                end
            end
            ST_DISP_MOVE:
            begin
                cmd.wr_en     = 1'b1;
                cmd.wr_sel    = WR_MOVE;
                cmd.count_dec = 1'b1;
                cmd.idx_inc   = 1'b1;
                state_next    = ST_DISP_RD;
            end
            ST_FINISH:
            begin
                if (status.flush_ready)
                begin
                    cmd.flush  = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

// ----- sv/periodic_task_table_scheduler.sv -----
// ============================================================================
// Periodic task table scheduler - top level
// Compact task table with set, delete, tick and dispatch requests.
// ============================================================================
// Usage:
//   One request word enters on req (req_valid/req_stall) and gives zero or
//   more result words on res (res_valid/res_stall); the final word of each
//   request carries last_of_run. A tick gives no result word.
//   One request is worked on at a time. The table sits in a memory with one
//   registered read port, so each visited slot is first read and then checked
//   or written. A tick only sets a flag; a later dispatch first walks the
//   table to apply it, then walks it again for due tasks. Set and delete
//   search slot by slot; dispatch deletes the one-shot entries it reports.
//   A new request is taken while the last result word still waits on res.
//   Reset clears the entry count, the tick flag and all handshake state; the
//   table contents are left as they are and need no clearing pass.
//   A stalled receiver holds the output word; the walk pauses at the next
//   due task until the result stage takes it or MAX_RESULTS results are given.
// ============================================================================
`default_nettype none

module periodic_task_table_scheduler #(
    parameter int TABLE_SLOTS = ptts_pkg::TABLE_SLOTS_DEF
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                req_valid,
    output logic                     req_stall,
    input  wire ptts_pkg::req_word_t req,
    output logic                     res_valid,
    input  wire logic                res_stall,
    output ptts_pkg::res_word_t      res
);

    import ptts_pkg::*;

    cmd_t    cmd;
    status_t status;

    // Sequencer: decides which slot to read or write and when to report
    ptts_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .status    (status),
        .cmd       (cmd)
    );

    // Table, counters, hold stage and output register
    ptts_dpath #(
        .TABLE_SLOTS (TABLE_SLOTS)
    ) u_dpath (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .cmd       (cmd),
        .status    (status),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res       (res)
    );

    // A taken request blocks the input until its walk is done
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && !req_stall |=> req_stall)
        else $error("request accepted while previous one still in progress");

    // Never append to a full table
    a_no_overfill: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.count_inc |-> !status.full)
        else $error("append into a full table");

    // A result is only produced when the hold stage can release its word
    a_emit_room: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |-> status.emit_ready)
        else $error("result produced with no room in the output stage");

    // Final word of a request only leaves when the output register is free
    a_flush_room: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.flush |-> status.flush_ready)
        else $error("final word flushed into a busy output register");

endmodule

`default_nettype wire
